// ===== src/imhd_pkg.sv =====
package imhd_pkg;

  // Widths of the request and result fields.
  localparam int OP_W     = 2;
  localparam int KEY_W    = 10;
  localparam int VAL_IO_W = 16;
  localparam int ST_W     = 3;
  localparam int CNT_IO_W = 11;

  // Defaults for the top-level parameters.
  localparam int DEF_MAX_KEYS   = 1024;
  localparam int DEF_VALUE_BITS = 16;

  // Operation codes.
  localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
  localparam logic [OP_W-1:0] OP_DEC    = 2'd1;
  localparam logic [OP_W-1:0] OP_POP    = 2'd2;

  // Status codes.
  localparam logic [ST_W-1:0] ST_DONE   = 3'd0;
  localparam logic [ST_W-1:0] ST_EMPTY  = 3'd1;
  localparam logic [ST_W-1:0] ST_FULL   = 3'd2;
  localparam logic [ST_W-1:0] ST_DUP    = 3'd3;
  localparam logic [ST_W-1:0] ST_ABSENT = 3'd4;

  typedef struct packed {
    logic [OP_W-1:0]     operation;
    logic [KEY_W-1:0]    item_key;
    logic [VAL_IO_W-1:0] item_value;
  } in_payload_t;

  typedef struct packed {
    logic [ST_W-1:0]     status;
    logic [KEY_W-1:0]    popped_key;
    logic [VAL_IO_W-1:0] popped_value;
    logic [CNT_IO_W-1:0] entry_count;
  } out_payload_t;

endpackage

// ===== src/indexed_min_heap_decrement_unit.sv =====
// Indexed binary min-heap of (key, value) pairs with a per-key position table.
// Each request inserts a pair, decrements the value of a present key by one
// (saturating at zero), or pops the minimum, and gives exactly one result with
// a status, the popped pair and the entry count. One request is worked on at a
// time: in_ready is high only while the sequencer is idle. The sift-up walks
// one level per cycle, while the sift-down goes through S_DN_PICK and then
// S_DN_CMP for each level because both children and then the hole go through
// the single shared value comparator. A request rejected for a full heap, an
// empty heap, an out-of-range key or an unknown code goes from S_IDLE straight
// to S_DONE; a duplicate or absent key found in the position table ends after
// S_POS, a pop of the last entry after S_POP0, and a decrement of a zero value
// after S_POS and S_FETCH. After reset the position table is cleared one key
// per cycle, which keeps in_ready low until all min(MAX_KEYS, 1024) keys are
// cleared. A finished result sits in an output register, so the next request
// can be taken while out_valid waits.
module indexed_min_heap_decrement_unit
  import imhd_pkg::*;
#(
  parameter int MAX_KEYS   = DEF_MAX_KEYS,
  parameter int VALUE_BITS = DEF_VALUE_BITS
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_valid,
  output logic         in_ready,
  input  in_payload_t  in_data,
  output logic         out_valid,
  input  logic         out_ready,
  output out_payload_t out_data
);

  logic         res_valid;
  logic         res_ready;
  out_payload_t res;

  // The sequencer owns both memories and the shared comparator.
  imhd_seq #(
    .MAX_KEYS   (MAX_KEYS),
    .VALUE_BITS (VALUE_BITS)
  ) u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (in_valid),
    .req_ready (in_ready),
    .req       (in_data),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  // Output register: a new result loads when the register is empty or is
  // being drained in the same cycle.
  logic         out_valid_r, out_valid_nxt;
  out_payload_t out_data_r, out_data_nxt;

  assign res_ready = !out_valid_r || out_ready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (res_valid && res_ready) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = res;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ===== src/imhd_heap_mem.sv =====
module imhd_heap_mem
  import imhd_pkg::*;
#(
  parameter int DEPTH = DEF_MAX_KEYS,
  parameter int AW    = $clog2(DEF_MAX_KEYS),
  parameter int DW    = KEY_W + DEF_VALUE_BITS
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic          re_a,
  input  logic [AW-1:0] raddr_a,
  output logic [DW-1:0] rdata_a,
  input  logic          re_b,
  input  logic [AW-1:0] raddr_b,
  output logic [DW-1:0] rdata_b
);

  logic [DW-1:0] mem [DEPTH];

  // Read data holds until the next read on that port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re_a) begin
      rdata_a <= mem[raddr_a];
    end
    if (re_b) begin
      rdata_b <= mem[raddr_b];
    end
  end

endmodule

// ===== src/imhd_pos_mem.sv =====
module imhd_pos_mem
  import imhd_pkg::*;
#(
  parameter int DEPTH = DEF_MAX_KEYS,
  parameter int AW    = $clog2(DEF_MAX_KEYS),
  parameter int DW    = $clog2(DEF_MAX_KEYS) + 1
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== src/imhd_seq.sv =====
module imhd_seq
  import imhd_pkg::*;
#(
  parameter int MAX_KEYS   = DEF_MAX_KEYS,
  parameter int VALUE_BITS = DEF_VALUE_BITS
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         req_valid,
  output logic         req_ready,
  input  in_payload_t  req,
  output logic         res_valid,
  input  logic         res_ready,
  output out_payload_t res
);

  localparam int HA_W      = $clog2(MAX_KEYS);
  localparam int CNT_W     = $clog2(MAX_KEYS + 1);
  localparam int KEY_DEPTH = (MAX_KEYS > (1 << KEY_W)) ? (1 << KEY_W) : MAX_KEYS;
  localparam int KEY_AW    = $clog2(KEY_DEPTH);
  localparam int ENT_W     = KEY_W + VALUE_BITS;
  localparam int POS_W     = HA_W + 1;

  localparam logic [CNT_W-1:0]  CNT_FULL = CNT_W'(MAX_KEYS);
  localparam logic [KEY_W:0]    KEY_LIM  = (KEY_W + 1)'(KEY_DEPTH);
  localparam logic [KEY_AW-1:0] KEY_LAST = KEY_AW'(KEY_DEPTH - 1);

  typedef enum logic [10:0] {
    S_CLEAR   = 11'b00000000001,
    S_IDLE    = 11'b00000000010,
    S_POS     = 11'b00000000100,
    S_FETCH   = 11'b00000001000,
    S_POP0    = 11'b00000010000,
    S_LAST    = 11'b00000100000,
    S_UP      = 11'b00001000000,
    S_DN_PICK = 11'b00010000000,
    S_DN_CMP  = 11'b00100000000,
    S_PLACE   = 11'b01000000000,
    S_DONE    = 11'b10000000000
  } state_t;

  state_t state_r, state_nxt;

  logic [KEY_AW-1:0]     clr_idx_r, clr_idx_nxt;
  logic [CNT_W-1:0]      cnt_r, cnt_nxt;
  logic [OP_W-1:0]       op_r, op_nxt;
  logic [KEY_W-1:0]      hkey_r, hkey_nxt;
  logic [VALUE_BITS-1:0] hval_r, hval_nxt;
  logic [HA_W-1:0]       at_r, at_nxt;
  logic [KEY_W-1:0]      pick_key_r, pick_key_nxt;
  logic [VALUE_BITS-1:0] pick_val_r, pick_val_nxt;
  logic [HA_W-1:0]       pick_idx_r, pick_idx_nxt;
  logic [ST_W-1:0]       status_r, status_nxt;
  logic [KEY_W-1:0]      pk_r, pk_nxt;
  logic [VALUE_BITS-1:0] pv_r, pv_nxt;

  // Memory ports.
  logic              hp_we, hp_re_a, hp_re_b;
  logic [HA_W-1:0]   hp_waddr, hp_raddr_a, hp_raddr_b;
  logic [ENT_W-1:0]  hp_wdata, hp_rdata_a, hp_rdata_b;
  logic              ps_we, ps_re;
  logic [KEY_AW-1:0] ps_waddr, ps_raddr;
  logic [POS_W-1:0]  ps_wdata, ps_rdata;

  imhd_heap_mem #(
    .DEPTH (MAX_KEYS),
    .AW    (HA_W),
    .DW    (ENT_W)
  ) u_heap (
    .clk     (clk),
    .we      (hp_we),
    .waddr   (hp_waddr),
    .wdata   (hp_wdata),
    .re_a    (hp_re_a),
    .raddr_a (hp_raddr_a),
    .rdata_a (hp_rdata_a),
    .re_b    (hp_re_b),
    .raddr_b (hp_raddr_b),
    .rdata_b (hp_rdata_b)
  );

  imhd_pos_mem #(
    .DEPTH (KEY_DEPTH),
    .AW    (KEY_AW),
    .DW    (POS_W)
  ) u_pos (
    .clk   (clk),
    .we    (ps_we),
    .waddr (ps_waddr),
    .wdata (ps_wdata),
    .re    (ps_re),
    .raddr (ps_raddr),
    .rdata (ps_rdata)
  );

  logic [KEY_W-1:0]      rd_a_key, rd_b_key;
  logic [VALUE_BITS-1:0] rd_a_val, rd_b_val;
  assign rd_a_key = hp_rdata_a[ENT_W-1 -: KEY_W];
  assign rd_a_val = hp_rdata_a[VALUE_BITS-1:0];
  assign rd_b_key = hp_rdata_b[ENT_W-1 -: KEY_W];
  assign rd_b_val = hp_rdata_b[VALUE_BITS-1:0];

  logic             pos_present;
  logic [HA_W-1:0]  pos_at;
  assign pos_present = ps_rdata[POS_W-1];
  assign pos_at      = ps_rdata[HA_W-1:0];

  // Request field conversions.
  logic [VALUE_BITS+VAL_IO_W-1:0] vin_ext;
  logic [VALUE_BITS-1:0]          req_val;
  logic                           req_oob;
  assign vin_ext = {{VALUE_BITS{1'b0}}, req.item_value};
  assign req_val = vin_ext[VALUE_BITS-1:0];
  assign req_oob = ({1'b0, req.item_key} >= KEY_LIM);

  // Parent of the position the sift-up moves to next.
  logic [HA_W-1:0] up_base, up_par;
  assign up_par = (up_base - HA_W'(1)) >> 1;

  always_comb begin
    case (state_r)
      S_POS:   up_base = cnt_r[HA_W-1:0];
      // Read data in S_UP is the parent of at_r.
      S_UP:    up_base = (at_r - HA_W'(1)) >> 1;
      default: up_base = at_r;
    endcase
  end

  // Children of the current hole (or of the child just moved up).
  logic [HA_W-1:0]  dn_base;
  logic [CNT_W:0]   dn_left, dn_right;
  logic             dn_left_ok, dn_right_ok;
  assign dn_base     = (state_r == S_DN_CMP) ? pick_idx_r : at_r;
  assign dn_left     = (CNT_W + 1)'({dn_base, 1'b1});
  assign dn_right    = dn_left + (CNT_W + 1)'(1);
  assign dn_left_ok  = dn_left < {1'b0, cnt_r};
  assign dn_right_ok = dn_right < {1'b0, cnt_r};

  // The one shared value comparator.
  logic [VALUE_BITS-1:0] cmp_a, cmp_b;
  logic                  cmp_lt;
  assign cmp_lt = cmp_a < cmp_b;

  always_comb begin
    case (state_r)
      S_DN_PICK: begin
        cmp_a = rd_b_val;
        cmp_b = rd_a_val;
      end
      S_DN_CMP: begin
        cmp_a = pick_val_r;
        cmp_b = hval_r;
      end
      default: begin
        cmp_a = hval_r;
        cmp_b = rd_a_val;
      end
    endcase
  end

  always_comb begin
    state_nxt    = state_r;
    clr_idx_nxt  = clr_idx_r;
    cnt_nxt      = cnt_r;
    op_nxt       = op_r;
    hkey_nxt     = hkey_r;
    hval_nxt     = hval_r;
    at_nxt       = at_r;
    pick_key_nxt = pick_key_r;
    pick_val_nxt = pick_val_r;
    pick_idx_nxt = pick_idx_r;
    status_nxt   = status_r;
    pk_nxt       = pk_r;
    pv_nxt       = pv_r;

    hp_we      = 1'b0;
    hp_waddr   = at_r;
    hp_wdata   = {hkey_r, hval_r};
    hp_re_a    = 1'b0;
    hp_raddr_a = up_par;
    hp_re_b    = 1'b0;
    hp_raddr_b = dn_right[HA_W-1:0];
    ps_we      = 1'b0;
    ps_waddr   = hkey_r[KEY_AW-1:0];
    ps_wdata   = {1'b1, at_r};
    ps_re      = 1'b0;
    ps_raddr   = req.item_key[KEY_AW-1:0];

    case (state_r)
      S_CLEAR: begin
        ps_we       = 1'b1;
        ps_waddr    = clr_idx_r;
        ps_wdata    = '0;
        clr_idx_nxt = clr_idx_r + KEY_AW'(1);
        if (clr_idx_r == KEY_LAST) begin
          state_nxt = S_IDLE;
        end
      end

      S_IDLE: begin
        if (req_valid) begin
          op_nxt     = req.operation;
          hkey_nxt   = req.item_key;
          hval_nxt   = req_val;
          status_nxt = ST_DONE;
          pk_nxt     = '0;
          pv_nxt     = '0;
          case (req.operation)
            OP_INSERT: begin
              if (cnt_r == CNT_FULL) begin
                status_nxt = ST_FULL;
                state_nxt  = S_DONE;
              end else if (req_oob) begin
                status_nxt = ST_ABSENT;
                state_nxt  = S_DONE;
              end else begin
                ps_re     = 1'b1;
                state_nxt = S_POS;
              end
            end
            OP_DEC: begin
              if (req_oob) begin
                status_nxt = ST_ABSENT;
                state_nxt  = S_DONE;
              end else begin
                ps_re     = 1'b1;
                state_nxt = S_POS;
              end
            end
            OP_POP: begin
              if (cnt_r == '0) begin
                status_nxt = ST_EMPTY;
                state_nxt  = S_DONE;
              end else begin
                hp_re_a    = 1'b1;
                hp_raddr_a = '0;
                state_nxt  = S_POP0;
              end
            end
            default: begin
              state_nxt = S_DONE;
            end
          endcase
        end
      end

      S_POS: begin
        if (op_r == OP_INSERT) begin
          if (pos_present) begin
            status_nxt = ST_DUP;
            state_nxt  = S_DONE;
          end else begin
            at_nxt  = cnt_r[HA_W-1:0];
            cnt_nxt = cnt_r + CNT_W'(1);
            if (cnt_r == '0) begin
              state_nxt = S_PLACE;
            end else begin
              hp_re_a   = 1'b1;
              state_nxt = S_UP;
            end
          end
        end else begin
          if (!pos_present) begin
            status_nxt = ST_ABSENT;
            state_nxt  = S_DONE;
          end else begin
            at_nxt     = pos_at;
            hp_re_a    = 1'b1;
            hp_raddr_a = pos_at;
            state_nxt  = S_FETCH;
          end
        end
      end

      S_FETCH: begin
        if (rd_a_val == '0) begin
          state_nxt = S_DONE;
        end else begin
          hval_nxt = rd_a_val - VALUE_BITS'(1);
          if (at_r == '0) begin
            state_nxt = S_PLACE;
          end else begin
            hp_re_a   = 1'b1;
            state_nxt = S_UP;
          end
        end
      end

      S_UP: begin
        // Read data is the parent of at_r.
        if (cmp_lt) begin
          hp_we    = 1'b1;
          hp_wdata = hp_rdata_a;
          ps_we    = 1'b1;
          ps_waddr = rd_a_key[KEY_AW-1:0];
          at_nxt   = up_base;
          if (up_base == '0) begin
            state_nxt = S_PLACE;
          end else begin
            hp_re_a = 1'b1;
          end
        end else begin
          state_nxt = S_PLACE;
        end
      end

      S_POP0: begin
        pk_nxt   = rd_a_key;
        pv_nxt   = rd_a_val;
        ps_we    = 1'b1;
        ps_waddr = rd_a_key[KEY_AW-1:0];
        ps_wdata = '0;
        cnt_nxt  = cnt_r - CNT_W'(1);
        at_nxt   = '0;
        if (cnt_r == CNT_W'(1)) begin
          state_nxt = S_DONE;
        end else begin
          hp_re_a    = 1'b1;
          hp_raddr_a = cnt_nxt[HA_W-1:0];
          state_nxt  = S_LAST;
        end
      end

      S_LAST: begin
        hkey_nxt = rd_a_key;
        hval_nxt = rd_a_val;
        if (dn_left_ok) begin
          hp_re_a    = 1'b1;
          hp_raddr_a = dn_left[HA_W-1:0];
          hp_re_b    = 1'b1;
          state_nxt  = S_DN_PICK;
        end else begin
          state_nxt = S_PLACE;
        end
      end

      S_DN_PICK: begin
        // Right child wins only when it is strictly smaller.
        if (dn_right_ok && cmp_lt) begin
          pick_key_nxt = rd_b_key;
          pick_val_nxt = rd_b_val;
          pick_idx_nxt = dn_right[HA_W-1:0];
        end else begin
          pick_key_nxt = rd_a_key;
          pick_val_nxt = rd_a_val;
          pick_idx_nxt = dn_left[HA_W-1:0];
        end
        state_nxt = S_DN_CMP;
      end

      S_DN_CMP: begin
        if (cmp_lt) begin
          hp_we    = 1'b1;
          hp_wdata = {pick_key_r, pick_val_r};
          ps_we    = 1'b1;
          ps_waddr = pick_key_r[KEY_AW-1:0];
          at_nxt   = pick_idx_r;
          if (dn_left_ok) begin
            hp_re_a    = 1'b1;
            hp_raddr_a = dn_left[HA_W-1:0];
            hp_re_b    = 1'b1;
            state_nxt  = S_DN_PICK;
          end else begin
            state_nxt = S_PLACE;
          end
        end else begin
          state_nxt = S_PLACE;
        end
      end

      S_PLACE: begin
        hp_we     = 1'b1;
        ps_we     = 1'b1;
        state_nxt = S_DONE;
      end

      S_DONE: begin
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_CLEAR;
      clr_idx_r <= '0;
      cnt_r     <= '0;
    end else begin
      state_r   <= state_nxt;
      clr_idx_r <= clr_idx_nxt;
      cnt_r     <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r       <= op_nxt;
    hkey_r     <= hkey_nxt;
    hval_r     <= hval_nxt;
    at_r       <= at_nxt;
    pick_key_r <= pick_key_nxt;
    pick_val_r <= pick_val_nxt;
    pick_idx_r <= pick_idx_nxt;
    status_r   <= status_nxt;
    pk_r       <= pk_nxt;
    pv_r       <= pv_nxt;
  end

  // Result assembly.
  logic [VALUE_BITS+VAL_IO_W-1:0] vout_ext;
  logic [CNT_W+CNT_IO_W-1:0]      cnt_ext;
  assign vout_ext = {{VAL_IO_W{1'b0}}, pv_r};
  assign cnt_ext  = {{CNT_IO_W{1'b0}}, cnt_r};

  assign req_ready          = (state_r == S_IDLE);
  assign res_valid          = (state_r == S_DONE);
  assign res.status         = status_r;
  assign res.popped_key     = pk_r;
  assign res.popped_value   = vout_ext[VAL_IO_W-1:0];
  assign res.entry_count    = cnt_ext[CNT_IO_W-1:0];

endmodule
